[sv/xmul_pkg.sv]
// Package of the unsigned multiply unit: size codes, payload and stage types.
`default_nettype none

package xmul_pkg;

	// Number of register stages between an accepted input and a presented result.
	localparam int unsigned DEPTH = 4;

	typedef enum logic [1:0] {
		SZ8  = 2'd0,
		SZ16 = 2'd1,
		SZ32 = 2'd2,
		SZ64 = 2'd3
	} size_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] acc_in;
		logic [63:0] high_in;
		logic [63:0] operand_value;
	} xmul_in_t;

	typedef struct packed {
		logic [63:0] acc_out;
		logic [63:0] high_out;
		logic        carry_flag;
		logic        overflow_flag;
	} xmul_out_t;

	// Partial products of the masked operands.
	typedef struct packed {
		size_t       size;
		logic [63:0] acc;
		logic [63:0] rdx;
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
	} pp_t;

	// Column sums of the partial products.
	typedef struct packed {
		size_t       size;
		logic [63:0] acc;
		logic [63:0] rdx;
		logic [31:0] lo32;
		logic [33:0] mid;
		logic [63:0] hsum;
	} colsum_t;

	// Full 128-bit product.
	typedef struct packed {
		size_t       size;
		logic [63:0] acc;
		logic [63:0] rdx;
		logic [63:0] lo;
		logic [63:0] hi;
	} prod_t;

endpackage

`default_nettype wire

[sv/xmul_in_if.sv]
// Input channel of the unsigned multiply unit.
`default_nettype none

interface xmul_in_if;
	logic                valid;
	logic                ready;
	xmul_pkg::xmul_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/xmul_out_if.sv]
// Result channel of the unsigned multiply unit.
`default_nettype none

interface xmul_out_if;
	logic                valid;
	logic                ready;
	xmul_pkg::xmul_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/xmul_ppmul.sv]
// First stage: operand masking and four 32x32 partial products.
`default_nettype none

module xmul_ppmul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xmul_pkg::xmul_in_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output xmul_pkg::pp_t      out_data
);
	import xmul_pkg::*;

	size_t       size;
	logic [63:0] a;
	logic [63:0] b;
	logic [63:0] p00;
	logic [63:0] p01;
	logic [63:0] p10;
	logic [63:0] p11;
	logic        valid_s1;
	pp_t         pp_s1;

	assign size = size_t'(in_data.cmd);

	always_comb begin
		case (size)
			SZ8: begin
				a = {56'd0, in_data.acc_in[7:0]};
				b = {56'd0, in_data.operand_value[7:0]};
			end
			SZ16: begin
				a = {48'd0, in_data.acc_in[15:0]};
				b = {48'd0, in_data.operand_value[15:0]};
			end
			SZ32: begin
				a = {32'd0, in_data.acc_in[31:0]};
				b = {32'd0, in_data.operand_value[31:0]};
			end
			default: begin
				a = in_data.acc_in;
				b = in_data.operand_value;
			end
		endcase
	end

	assign p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
	assign p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
	assign p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
	assign p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pp_s1.size <= size;
			pp_s1.acc  <= in_data.acc_in;
			pp_s1.rdx  <= in_data.high_in;
			pp_s1.p00  <= p00;
			pp_s1.p01  <= p01;
			pp_s1.p10  <= p10;
			pp_s1.p11  <= p11;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = pp_s1;

endmodule

`default_nettype wire

[sv/xmul_reduce.sv]
// Second and third stages: column sums, then the final carry into the upper half.
`default_nettype none

module xmul_reduce (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  xmul_pkg::pp_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output xmul_pkg::prod_t out_data
);
	import xmul_pkg::*;

	logic    valid_s2;
	logic    valid_s3;
	logic    ready_s2;
	colsum_t cs_s2;
	prod_t   prod_s3;

	assign ready_s2 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// The middle column can carry up to two into the upper half; the upper
	// column itself cannot overflow, as the true product fits in 128 bits.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cs_s2.size <= in_data.size;
			cs_s2.acc  <= in_data.acc;
			cs_s2.rdx  <= in_data.rdx;
			cs_s2.lo32 <= in_data.p00[31:0];
			cs_s2.mid  <= {2'd0, in_data.p00[63:32]} + {2'd0, in_data.p01[31:0]}
				+ {2'd0, in_data.p10[31:0]};
			cs_s2.hsum <= in_data.p11 + {32'd0, in_data.p01[63:32]}
				+ {32'd0, in_data.p10[63:32]};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			prod_s3.size <= cs_s2.size;
			prod_s3.acc  <= cs_s2.acc;
			prod_s3.rdx  <= cs_s2.rdx;
			prod_s3.lo   <= {cs_s2.mid[31:0], cs_s2.lo32};
			prod_s3.hi   <= cs_s2.hsum + {62'd0, cs_s2.mid[33:32]};
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = prod_s3;

endmodule

`default_nettype wire

[sv/xmul_merge.sv]
// Output stage: merge of the product into the registers per size, and the flags.
`default_nettype none

module xmul_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  xmul_pkg::prod_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output xmul_pkg::xmul_out_t out_data
);
	import xmul_pkg::*;

	logic      valid_s4;
	xmul_out_t res;
	xmul_out_t res_s4;
	logic      upper;

	always_comb begin
		case (in_data.size)
			SZ8: begin
				res.acc_out  = {in_data.acc[63:16], in_data.lo[15:0]};
				res.high_out = in_data.rdx;
				upper        = |in_data.lo[15:8];
			end
			SZ16: begin
				res.acc_out  = {in_data.acc[63:16], in_data.lo[15:0]};
				res.high_out = {in_data.rdx[63:16], in_data.lo[31:16]};
				upper        = |in_data.lo[31:16];
			end
			SZ32: begin
				res.acc_out  = {32'd0, in_data.lo[31:0]};
				res.high_out = {32'd0, in_data.lo[63:32]};
				upper        = |in_data.lo[63:32];
			end
			default: begin
				res.acc_out  = in_data.lo;
				res.high_out = in_data.hi;
				upper        = |in_data.hi;
			end
		endcase
		res.carry_flag    = upper;
		res.overflow_flag = upper;
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s4 <= res;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = res_s4;

endmodule

`default_nettype wire

[sv/x86_unsigned_multiply_unit_core.sv]
// Top level of the x86 unsigned multiply unit (MUL at 8, 16, 32 and 64 bits).
//
//   Channel   Role     Payload                                         Transfer
//   req       sink     cmd, acc_in, high_in, operand_value             valid && ready
//   rsp       source   acc_out, high_out, carry_flag, overflow_flag    valid && ready
//
// One item enters in every cycle while req.ready is high. Four register stages
// hold an item: partial products, column sums, upper carry, then merge and
// flags. A result is offered on rsp from the merge register.
// Reset clears only the stage valid bits; the pipeline then holds no item.
// A stall on rsp fills the empty stages first and then holds every stage in
// place, so no item is lost or repeated; req.ready falls only when all four
// stages hold an item and rsp is stalled.
`default_nettype none

module x86_unsigned_multiply_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	xmul_in_if.sink     req,
	xmul_out_if.source  rsp
);
	import xmul_pkg::*;

	// Handshake between the stage groups.
	logic    pp_valid;
	logic    pp_ready;
	pp_t     pp_data;
	logic    prod_valid;
	logic    prod_ready;
	prod_t   prod_data;

	// The 64x64 product is built from four 32x32 partial products, one
	// multiplier per partial product, all in the first stage.
	xmul_ppmul u_ppmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_data   (req.data),
		.out_valid (pp_valid),
		.out_ready (pp_ready),
		.out_data  (pp_data)
	);

	// Two stages of additions: the three column sums, then the carry of the
	// middle column into the upper half.
	xmul_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pp_valid),
		.in_ready  (pp_ready),
		.in_data   (pp_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	// The product half is merged into RAX and RDX according to the operand
	// size, and the flags test the upper half; the result register here
	// parts the pipeline from the consumer.
	xmul_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod_data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp.data)
	);

endmodule

`default_nettype wire

[sv/xmul_checker.sv]
// Port-level checker of the unsigned multiply unit and its bind to the top level.
`default_nettype none

module xmul_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input xmul_pkg::xmul_out_t rsp_data
);
	import xmul_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic          in_xfer;
	logic          out_xfer;
	logic [CW-1:0] inflight_q;

	assign in_xfer  = req_valid && req_ready;
	assign out_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	// A stalled result stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed or dropped while stalled");

	// The pipeline never holds more items than it has stages.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(DEPTH))
		else $error("more items in flight than pipeline stages");

	// No result is offered without an item in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != '0)
		else $error("result offered with no item in flight");

	// Input back-pressure only arises when items are held.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> inflight_q != '0)
		else $error("input blocked while pipeline is empty");

	// A full pipeline with a stalled result must refuse new input.
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CW'(DEPTH) && !rsp_ready |-> !req_ready)
		else $error("input accepted while pipeline is full and stalled");

endmodule

bind x86_unsigned_multiply_unit_core xmul_checker u_xmul_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench of the x86 unsigned multiply unit at all four operand sizes.
`timescale 1ns / 1ps

module tb_top;
	import xmul_pkg::*;

	// The run stops here, far beyond the slowest correct run. That run is about
	// 1020 items, each with the longest send gap, the longest receive stall and the
	// pipeline depth.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1000;
	localparam int unsigned MAX_WAIT     = 15;

	// One row of stimulus. Where the product can be read off at a glance, the
	// expected result is typed in beside it. Every other row goes to the predictor.
	typedef struct packed {
		xmul_in_t  stim;
		logic      typed;
		xmul_out_t want;
	} mul_row_t;

	logic clk;
	logic arst_n;

	xmul_in_if  req_bus ();
	xmul_out_if rsp_bus ();

	x86_unsigned_multiply_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// The expected results of accepted items, oldest first.
	xmul_out_t   pending_products[$];
	mul_row_t    directed_rows[$];
	mul_row_t    cur_row;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	// The free-running clock has a period of 20 ns.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// This is the predictor. It masks both factors to the selected size and forms
	// the full product. It then merges the halves into RAX and RDX, which is where
	// the x86 rules differ from one size to the next.
	function automatic xmul_out_t mul_predict(xmul_in_t x);
		logic [63:0]  a;
		logic [63:0]  b;
		logic [127:0] prod;
		xmul_out_t    r;
		case (size_t'(x.cmd))
			SZ8: begin
				a = {56'd0, x.acc_in[7:0]};
				b = {56'd0, x.operand_value[7:0]};
			end
			SZ16: begin
				a = {48'd0, x.acc_in[15:0]};
				b = {48'd0, x.operand_value[15:0]};
			end
			SZ32: begin
				a = {32'd0, x.acc_in[31:0]};
				b = {32'd0, x.operand_value[31:0]};
			end
			default: begin
				a = x.acc_in;
				b = x.operand_value;
			end
		endcase
		prod = {64'd0, a} * {64'd0, b};
		case (size_t'(x.cmd))
			SZ8: begin
				// AX takes the whole 16-bit product. RDX does not take part.
				r.acc_out    = {x.acc_in[63:16], prod[15:0]};
				r.high_out   = x.high_in;
				r.carry_flag = |prod[15:8];
			end
			SZ16: begin
				r.acc_out    = {x.acc_in[63:16], prod[15:0]};
				r.high_out   = {x.high_in[63:16], prod[31:16]};
				r.carry_flag = |prod[31:16];
			end
			SZ32: begin
				// A 32-bit write clears the upper halves of both registers.
				r.acc_out    = {32'd0, prod[31:0]};
				r.high_out   = {32'd0, prod[63:32]};
				r.carry_flag = |prod[63:32];
			end
			default: begin
				r.acc_out    = prod[63:0];
				r.high_out   = prod[127:64];
				r.carry_flag = |prod[127:64];
			end
		endcase
		r.overflow_flag = r.carry_flag;
		return r;
	endfunction

	function automatic mul_row_t plain_row(size_t sz, logic [63:0] acc, logic [63:0] rdx,
			logic [63:0] op);
		mul_row_t r;
		r = '0;
		r.stim = '{cmd: sz, acc_in: acc, high_in: rdx, operand_value: op};
		return r;
	endfunction

	function automatic mul_row_t typed_row(size_t sz, logic [63:0] acc, logic [63:0] rdx,
			logic [63:0] op, logic [63:0] acc_want, logic [63:0] rdx_want, logic flag);
		mul_row_t r;
		r = plain_row(sz, acc, rdx, op);
		r.typed = 1'b1;
		r.want  = '{acc_out: acc_want, high_out: rdx_want, carry_flag: flag,
			overflow_flag: flag};
		return r;
	endfunction

	// Random register values. Edge values and bit patterns are mixed with numbers
	// made small by a shift.
	function automatic logic [63:0] rand_word();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = ~(64'd1 << $urandom_range(0, 63));
			4, 5: v = v >> $urandom_range(1, 63);
			default: ;
		endcase
		return v;
	endfunction

	// The wait before an item. Every fourth stretch of 64 items has no idling at
	// all. Elsewhere it is drawn at random, up to MAX_WAIT.
	function automatic int unsigned draw_wait(int unsigned n);
		if ((n / 64) % 4 == 3) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// This drives one row. It idles for the drawn gap, holds valid with the payload
	// and waits for the transfer. Valid stays high into the next row when no gap
	// comes between them.
	task automatic send_row(mul_row_t r, int unsigned n);
		int unsigned gap;
		gap = draw_wait(n);
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data  <= r.stim;
		cur_row       <= r;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	// Both channels are sampled at the same edge in one process. The expectation of
	// an incoming transfer is queued before any result is matched, so no outcome
	// rests on the order in which processes run within a time step.
	always @(posedge clk) begin
		xmul_out_t got;
		xmul_out_t want;
		if (req_bus.valid && req_bus.ready) begin
			if (cur_row.typed) begin
				pending_products.push_back(cur_row.want);
			end else begin
				pending_products.push_back(mul_predict(req_bus.data));
			end
		end
		if (rsp_bus.valid && rsp_bus.ready) begin
			got = rsp_bus.data;
			if (pending_products.size() == 0) begin
				note_mismatch("result with nothing pending, acc_out", got.acc_out, '0);
			end else begin
				want = pending_products.pop_front();
				if (got.acc_out !== want.acc_out) begin
					note_mismatch("acc_out", got.acc_out, want.acc_out);
				end
				if (got.high_out !== want.high_out) begin
					note_mismatch("high_out", got.high_out, want.high_out);
				end
				if (got.carry_flag !== want.carry_flag) begin
					note_mismatch("carry_flag", 64'(got.carry_flag), 64'(want.carry_flag));
				end
				if (got.overflow_flag !== want.overflow_flag) begin
					note_mismatch("overflow_flag", 64'(got.overflow_flag),
						64'(want.overflow_flag));
				end
			end
		end
	end

	// The watchdog. A hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// The receiving side stalls for a freshly drawn number of cycles before each
	// result. It then holds ready until a transfer takes place.
	initial begin
		int unsigned taken;
		int unsigned stall;
		rsp_bus.ready <= 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(taken);
			if (stall != 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			taken++;
		end
	end

	initial begin
		int unsigned n;
		mul_row_t    r;
		mismatch_count = 0;
		cycle_count    = 0;
		arst_n         <= 1'b0;
		req_bus.valid  <= 1'b0;
		req_bus.data   <= '0;
		cur_row        <= '0;

		// Directed table: zero products, the largest factors at every size, operand
		// bits above the size, kept and cleared upper register halves, and carries
		// that cross the middle of the 64-bit product.
		directed_rows.push_back(typed_row(SZ8, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0));
		directed_rows.push_back(typed_row(SZ8, 64'hA5A5_A5A5_A5A5_12FF,
			64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hA5A5_A5A5_A5A5_FE01, 64'h1234_5678_9ABC_DEF0, 1'b1));
		directed_rows.push_back(typed_row(SZ8, 64'hFFFF_FFFF_FFFF_FF07,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00,
			64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
		directed_rows.push_back(plain_row(SZ8, 64'h0000_0000_0000_000F, 64'h0,
			64'h0000_0000_0000_000F));
		directed_rows.push_back(plain_row(SZ8, 64'h8000_0000_0000_0010, 64'h5,
			64'h0000_0000_0000_0010));
		directed_rows.push_back(plain_row(SZ8, 64'h0000_0000_0000_0001, 64'h0,
			64'h7FFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(typed_row(SZ16, 64'hFFFF_FFFF_FFFF_0000,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_0000, 1'b0));
		directed_rows.push_back(typed_row(SZ16, 64'h0000_0000_0000_FFFF, 64'h0,
			64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_FFFE,
			1'b1));
		directed_rows.push_back(typed_row(SZ16, 64'hDEAD_BEEF_CAFE_FFFF,
			64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hDEAD_BEEF_CAFE_0001, 64'h0123_4567_89AB_FFFE, 1'b1));
		directed_rows.push_back(plain_row(SZ16, 64'h0000_0000_0000_00FF, 64'hFFFF,
			64'h0000_0000_0000_0101));
		directed_rows.push_back(typed_row(SZ32, 64'hFFFF_FFFF_0000_0002,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0003,
			64'h0000_0000_0000_0006, 64'h0, 1'b0));
		directed_rows.push_back(typed_row(SZ32, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_FFFE, 1'b1));
		directed_rows.push_back(typed_row(SZ32, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
			64'h0, 64'h0, 1'b0));
		directed_rows.push_back(plain_row(SZ32, 64'h0000_0000_0001_0000, 64'h3,
			64'h8000_0000_0001_0000));
		directed_rows.push_back(typed_row(SZ64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE,
			1'b1));
		directed_rows.push_back(typed_row(SZ64, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 1'b0));
		directed_rows.push_back(typed_row(SZ64, 64'h1, 64'hDEAD_BEEF_DEAD_BEEF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0));
		directed_rows.push_back(typed_row(SZ64, 64'h0000_0001_0000_0000, 64'h0,
			64'h0000_0001_0000_0000, 64'h0, 64'h1, 1'b1));
		directed_rows.push_back(typed_row(SZ64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
			64'h2, 64'hFFFF_FFFF_FFFF_FFFE, 64'h1, 1'b1));
		directed_rows.push_back(plain_row(SZ64, 64'h0123_4567_89AB_CDEF,
			64'h5555_5555_5555_5555, 64'hFEDC_BA98_7654_3210));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		n = 0;
		foreach (directed_rows[i]) begin
			send_row(directed_rows[i], n);
			n++;
		end

		// The random part. Every size is drawn evenly. The registers and the operand
		// are independent, so bits above the size are exercised as well.
		repeat (RANDOM_ITEMS) begin
			r = plain_row(size_t'($urandom_range(0, 3)), rand_word(), rand_word(),
				rand_word());
			send_row(r, n);
			n++;
		end
		req_bus.valid <= 1'b0;

		// A clock edge lets the monitor queue the last transfer. Then drain the pipeline,
		// and keep waiting afterwards so that any spurious result still has time to show up.
		@(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (pending_products.size() != 0) begin
			note_mismatch("results still pending", 64'(pending_products.size()), '0);
		end
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[files.f]
sv/xmul_pkg.sv
sv/xmul_in_if.sv
sv/xmul_out_if.sv
sv/xmul_ppmul.sv
sv/xmul_reduce.sv
sv/xmul_merge.sv
sv/x86_unsigned_multiply_unit_core.sv
sv/xmul_checker.sv
sim/tb_top.sv
